// File: rtl/srr_pkg.sv
// shared types, constants and codes of the serpentine rectangle rasterizer
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

  // field widths
  localparam int COORD_W  = 4;
  localparam int COLOUR_W = 24;
  localparam int INDEX_W  = 6;
  localparam int CFG_IDX_W = 2;

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // largest grid side that the 6-bit strip index can address
  localparam int HW_LIMIT = 8;

  // defaults for the top-level size parameters
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  // reset value of both grid size registers
  localparam logic [COORD_W-1:0] GRID_RESET = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TOP,
    ST_BOTTOM,
    ST_LEFT,
    ST_RIGHT
  } state_t;

  // walk position updates
  typedef enum logic [2:0] {
    WALK_HOLD,
    WALK_LOAD,
    WALK_COL_INC,
    WALK_ROW_INC,
    WALK_ROW_NEXT,
    WALK_TO_BOTTOM,
    WALK_TO_LEFT,
    WALK_TO_RIGHT
  } walk_op_t;

  // controller to datapath
  typedef struct packed {
    walk_op_t walk_op;
    logic     emit;
    logic     last;
  } srr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_at_hi;
    logic row_at_hi;
    logic out_free;
  } srr_status_t;

endpackage

`default_nettype wire

// File: rtl/serpentine_rectangle_rasterizer_core.sv
// top level of the serpentine rectangle rasterizer
//
//   channel   direction  ports                               content
//   s_*       in         s_tvalid s_tready s_tdata s_tuser   one rectangle command
//   m_*       out        m_tvalid m_tready m_tdata m_tlast   one pixel word
//   cfg_*     in         cfg_valid cfg_ready cfg_index/data  grid size writes
//
// a command is taken in idle, then one pixel word is produced per cycle while the
// output register is free; a fill gives (rows * cols) words, an outline 2 * (rows + cols)
// words of the clamped rectangle, set by the single walk counter pair; the next command is
// taken as soon as the final pixel sits in the output register
// a low m_tready holds the walk; rst is synchronous and returns to idle with
// both grid sizes at 8
`timescale 1ns / 1ps
`default_nettype none

module serpentine_rectangle_rasterizer_core #(
  parameter int MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // command words
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // row_a[3:0], col_a[7:4], row_b[11:8], col_b[15:12], colour[39:16]
  input  wire [srr_pkg::IN_DATA_W-1:0]      s_tdata,
  // fill_mode[0]
  input  wire                               s_tuser,
  // pixel words
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // pixel_index[5:0], pixel_colour[29:6], zero[31:30]
  output logic [srr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  // configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [srr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [srr_pkg::COORD_W-1:0]        cfg_data
);

  srr_pkg::srr_cmd_t    cmd;
  srr_pkg::srr_status_t status;

  logic [srr_pkg::INDEX_W-1:0]  pixel_index;
  logic [srr_pkg::COLOUR_W-1:0] pixel_colour;

  // writes are always taken
  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .fill_mode (s_tuser),
    .s_tready  (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  srr_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_a        (s_tdata[3:0]),
    .col_a        (s_tdata[7:4]),
    .row_b        (s_tdata[11:8]),
    .col_b        (s_tdata[15:12]),
    .colour       (s_tdata[39:16]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .pixel_index  (pixel_index),
    .pixel_colour (pixel_colour),
    .last_pixel   (m_tlast)
  );

  // pack the pixel word
  assign m_tdata = {2'b00, pixel_colour, pixel_index};

endmodule

`default_nettype wire

// File: rtl/srr_ctrl.sv
// controller state machine: walks the fill rows or the four outline segments
`timescale 1ns / 1ps
`default_nettype none

module srr_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       s_tvalid,
  input  wire                       fill_mode,
  output logic                      s_tready,
  input  wire srr_pkg::srr_status_t status,
  output srr_pkg::srr_cmd_t         cmd
);

  srr_pkg::state_t state;
  srr_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = fill_mode ? srr_pkg::ST_FILL : srr_pkg::ST_TOP;
        end
      end
      srr_pkg::ST_FILL: begin
        if (status.out_free && status.col_at_hi && status.row_at_hi) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_TOP: begin
        if (status.out_free && status.col_at_hi) begin
          state_next = srr_pkg::ST_BOTTOM;
        end
      end
      srr_pkg::ST_BOTTOM: begin
        if (status.out_free && status.col_at_hi) begin
          state_next = srr_pkg::ST_LEFT;
        end
      end
      srr_pkg::ST_LEFT: begin
        if (status.out_free && status.row_at_hi) begin
          state_next = srr_pkg::ST_RIGHT;
        end
      end
      srr_pkg::ST_RIGHT: begin
        if (status.out_free && status.row_at_hi) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srr_pkg::ST_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    s_tready    = 1'b0;
    cmd.walk_op = srr_pkg::WALK_HOLD;
    cmd.emit    = 1'b0;
    cmd.last    = 1'b0;
    case (state)
      srr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.walk_op = srr_pkg::WALK_LOAD;
        end
      end
      srr_pkg::ST_FILL: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!status.col_at_hi) begin
            cmd.walk_op = srr_pkg::WALK_COL_INC;
          end else if (!status.row_at_hi) begin
            cmd.walk_op = srr_pkg::WALK_ROW_NEXT;
          end else begin
            cmd.last = 1'b1;
          end
        end
      end
      srr_pkg::ST_TOP: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.walk_op = status.col_at_hi ? srr_pkg::WALK_TO_BOTTOM : srr_pkg::WALK_COL_INC;
        end
      end
      srr_pkg::ST_BOTTOM: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.walk_op = status.col_at_hi ? srr_pkg::WALK_TO_LEFT : srr_pkg::WALK_COL_INC;
        end
      end
      srr_pkg::ST_LEFT: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.walk_op = status.row_at_hi ? srr_pkg::WALK_TO_RIGHT : srr_pkg::WALK_ROW_INC;
        end
      end
      srr_pkg::ST_RIGHT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.row_at_hi) begin
            cmd.last = 1'b1;
          end else begin
            cmd.walk_op = srr_pkg::WALK_ROW_INC;
          end
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a pixel is only pushed into a free output register
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("pixel pushed into a full output register");

  // the final pixel always returns the controller to idle
  assert property (@(posedge clk) disable iff (rst) cmd.last |=> state == srr_pkg::ST_IDLE)
    else $error("controller not idle after final pixel");

  // an accepted command always starts a walk
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state != srr_pkg::ST_IDLE)
    else $error("accepted command did not start a walk");
`endif

endmodule

`default_nettype wire

// File: rtl/srr_datapath.sv
// datapath: grid registers, corner clamp and order, walk counters, strip index, output register
`timescale 1ns / 1ps
`default_nettype none

module srr_datapath #(
  parameter int MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration writes
  input  wire                                  cfg_valid,
  input  wire [srr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [srr_pkg::COORD_W-1:0]           cfg_data,
  // command fields
  input  wire [srr_pkg::COORD_W-1:0]           row_a,
  input  wire [srr_pkg::COORD_W-1:0]           col_a,
  input  wire [srr_pkg::COORD_W-1:0]           row_b,
  input  wire [srr_pkg::COORD_W-1:0]           col_b,
  input  wire [srr_pkg::COLOUR_W-1:0]          colour,
  // control
  input  wire srr_pkg::srr_cmd_t               cmd,
  output srr_pkg::srr_status_t                 status,
  // result word
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [srr_pkg::INDEX_W-1:0]          pixel_index,
  output logic [srr_pkg::COLOUR_W-1:0]         pixel_colour,
  output logic                                 last_pixel
);

  localparam int CW = srr_pkg::COORD_W;
  localparam int ROW_LIM_I = (MAX_ROWS < srr_pkg::HW_LIMIT) ? MAX_ROWS : srr_pkg::HW_LIMIT;
  localparam int COL_LIM_I = (MAX_COLS < srr_pkg::HW_LIMIT) ? MAX_COLS : srr_pkg::HW_LIMIT;
  localparam logic [CW-1:0] ROW_LIM = CW'((ROW_LIM_I < 1) ? 1 : ROW_LIM_I);
  localparam logic [CW-1:0] COL_LIM = CW'((COL_LIM_I < 1) ? 1 : COL_LIM_I);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [CW-1:0] grid_rows;
  logic [CW-1:0] grid_cols;
  logic [CW-1:0] eff_rows;
  logic [CW-1:0] eff_cols;

  logic [CW-1:0] ra_c, ca_c, rb_c, cb_c;
  logic [CW-1:0] row_lo, row_hi, col_lo, col_hi;
  logic [CW-1:0] walk_row, walk_col;
  logic [CW-1:0] walk_row_next, walk_col_next;
  logic [srr_pkg::COLOUR_W-1:0] held_colour;

  logic [CW-1:0]   row_off;
  logic [CW-1:0]   col_off;
  logic [2*CW-1:0] base;
  logic [2*CW-1:0] index_full;
  logic            out_free;

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] v,
                                                input logic [CW-1:0] n);
    logic [CW-1:0] r;
    begin
      if (v < ONE) r = ONE;
      else if (v > n) r = n;
      else r = v;
      return r;
    end
  endfunction

  // grid size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= srr_pkg::GRID_RESET;
      grid_cols <= srr_pkg::GRID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        srr_pkg::REG_GRID_ROWS: grid_rows <= cfg_data;
        srr_pkg::REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid size: zero counts as one, saturate at the hardware limit
  assign eff_rows = clamp_coord(grid_rows, ROW_LIM);
  assign eff_cols = clamp_coord(grid_cols, COL_LIM);

  // clamp the incoming corners to the grid
  assign ra_c = clamp_coord(row_a, eff_rows);
  assign ca_c = clamp_coord(col_a, eff_cols);
  assign rb_c = clamp_coord(row_b, eff_rows);
  assign cb_c = clamp_coord(col_b, eff_cols);

  // walk position update
  always_comb begin
    walk_row_next = walk_row;
    walk_col_next = walk_col;
    case (cmd.walk_op)
      srr_pkg::WALK_LOAD: begin
        walk_row_next = (ra_c < rb_c) ? ra_c : rb_c;
        walk_col_next = (ca_c < cb_c) ? ca_c : cb_c;
      end
      srr_pkg::WALK_COL_INC: begin
        walk_col_next = walk_col + ONE;
      end
      srr_pkg::WALK_ROW_INC: begin
        walk_row_next = walk_row + ONE;
      end
      srr_pkg::WALK_ROW_NEXT: begin
        walk_row_next = walk_row + ONE;
        walk_col_next = col_lo;
      end
      srr_pkg::WALK_TO_BOTTOM: begin
        walk_row_next = row_hi;
        walk_col_next = col_lo;
      end
      srr_pkg::WALK_TO_LEFT: begin
        walk_row_next = row_lo;
        walk_col_next = col_lo;
      end
      srr_pkg::WALK_TO_RIGHT: begin
        walk_row_next = row_lo;
        walk_col_next = col_hi;
      end
      default: ;
    endcase
  end

  // command registers: ordered corners, colour and walk position
  always_ff @(posedge clk) begin
    if (cmd.walk_op == srr_pkg::WALK_LOAD) begin
      row_lo      <= (ra_c < rb_c) ? ra_c : rb_c;
      row_hi      <= (ra_c < rb_c) ? rb_c : ra_c;
      col_lo      <= (ca_c < cb_c) ? ca_c : cb_c;
      col_hi      <= (ca_c < cb_c) ? cb_c : ca_c;
      held_colour <= colour;
    end
    walk_row <= walk_row_next;
    walk_col <= walk_col_next;
  end

  // serpentine strip index of the current walk position
  assign row_off    = eff_rows - walk_row;
  assign base       = {{CW{1'b0}}, row_off} * {{CW{1'b0}}, eff_cols};
  assign col_off    = (eff_rows[0] ^ walk_row[0]) ? (eff_cols - walk_col) : (walk_col - ONE);
  assign index_full = base + {{CW{1'b0}}, col_off};

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_index  <= index_full[srr_pkg::INDEX_W-1:0];
      pixel_colour <= held_colour;
      last_pixel   <= cmd.last;
    end
  end

  // status back to the controller
  assign status.col_at_hi = (walk_col == col_hi);
  assign status.row_at_hi = (walk_row == row_hi);
  assign status.out_free  = out_free;

`ifndef SYNTHESIS
  // an emitted pixel lies inside the ordered rectangle
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (walk_row >= row_lo && walk_row <= row_hi &&
                  walk_col >= col_lo && walk_col <= col_hi))
    else $error("walk left the rectangle");

  // an emitted pixel lies inside the effective grid
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> index_full < ({{CW{1'b0}}, eff_rows} * {{CW{1'b0}}, eff_cols}))
    else $error("strip index beyond the grid");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_index) && $stable(last_pixel)))
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

// File: tb/rectangle_pixel_checker.sv
// checker that predicts and compares the pixel words of the rectangle rasterizer
`timescale 1ns / 1ps

module rectangle_pixel_checker #(
  parameter int MAX_ROWS = srr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = srr_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // row_a[3:0], col_a[7:4], row_b[11:8], col_b[15:12], colour[39:16]
  input  logic [srr_pkg::IN_DATA_W-1:0]   s_tdata,
  // fill_mode[0]
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_index[5:0], pixel_colour[29:6], zero[31:30]
  input  logic [srr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srr_pkg::COORD_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending_words,
  output int                              rects_seen,
  output int                              pixels_seen
);
  import srr_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_word_t;

  // words still owed by the block, oldest first
  pixel_word_t pixel_due_q[$];

  // shadow copy of the grid size registers
  logic [COORD_W-1:0] grid_rows = GRID_RESET;
  logic [COORD_W-1:0] grid_cols = GRID_RESET;

  int errors = 0;
  int rects = 0;
  int pixels = 0;

  // geometry of the rectangle being expanded
  int                  cur_rows;
  int                  cur_cols;
  int                  cur_first;
  logic [COLOUR_W-1:0] cur_colour;

  // usable grid side: zero reads as one, saturates at the addressable limit
  function automatic int grid_side(logic [COORD_W-1:0] reg_val, int max_side);
    int lim;
    int v;
    lim = (max_side < HW_LIMIT) ? max_side : HW_LIMIT;
    if (lim < 1) lim = 1;
    v = reg_val;
    if (v < 1) v = 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int clip_coord(logic [COORD_W-1:0] raw, int side);
    int v;
    v = raw;
    if (v < 1) return 1;
    return (v > side) ? side : v;
  endfunction

  // serpentine strip position; rows alternate direction from the bottom up
  function automatic void queue_pixel(int r, int c);
    pixel_word_t w;
    int base;
    if (pixel_due_q.size() - cur_first >= 64) return;
    base = (cur_rows - r) * cur_cols;
    if ((cur_rows + r) % 2 == 0) w.index = INDEX_W'(base + c - 1);
    else w.index = INDEX_W'(base + cur_cols - c);
    w.colour = cur_colour;
    w.last = 1'b0;
    pixel_due_q.push_back(w);
  endfunction

  // one rectangle command into its sequence of pixel words
  task automatic expand_rectangle(input logic fill, input logic [IN_DATA_W-1:0] word);
    int ra, ca, rb, cb;
    int rlo, rhi, clo, chi;
    pixel_word_t tail;
    cur_rows = grid_side(grid_rows, MAX_ROWS);
    cur_cols = grid_side(grid_cols, MAX_COLS);
    ra = clip_coord(word[3:0], cur_rows);
    ca = clip_coord(word[7:4], cur_cols);
    rb = clip_coord(word[11:8], cur_rows);
    cb = clip_coord(word[15:12], cur_cols);
    cur_colour = word[16 +: COLOUR_W];
    cur_first = pixel_due_q.size();
    rlo = (ra < rb) ? ra : rb;
    rhi = (ra < rb) ? rb : ra;
    clo = (ca < cb) ? ca : cb;
    chi = (ca < cb) ? cb : ca;
    if (fill) begin
      for (int r = rlo; r <= rhi; r++)
        for (int c = clo; c <= chi; c++) queue_pixel(r, c);
    end else begin
      // top, bottom, left, right; corners come out twice
      for (int c = clo; c <= chi; c++) queue_pixel(rlo, c);
      for (int c = clo; c <= chi; c++) queue_pixel(rhi, c);
      for (int r = rlo; r <= rhi; r++) queue_pixel(r, clo);
      for (int r = rlo; r <= rhi; r++) queue_pixel(r, chi);
    end
    if (pixel_due_q.size() > cur_first) begin
      tail = pixel_due_q.pop_back();
      tail.last = 1'b1;
      pixel_due_q.push_back(tail);
    end
    rects++;
  endtask

  // compare one accepted pixel word with the oldest one owed
  task automatic check_pixel();
    pixel_word_t want;
    pixels++;
    if (pixel_due_q.size() == 0) begin
      errors++;
      $display("%0t: pixel word with nothing owed: index %0d colour %06h last %0b",
               $time, m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: COLOUR_W], m_tlast);
      return;
    end
    want = pixel_due_q.pop_front();
    if (m_tdata[INDEX_W-1:0] !== want.index) begin
      errors++;
      $display("%0t: pixel_index expected %0d actual %0d",
               $time, want.index, m_tdata[INDEX_W-1:0]);
    end
    if (m_tdata[INDEX_W +: COLOUR_W] !== want.colour) begin
      errors++;
      $display("%0t: pixel_colour expected %06h actual %06h",
               $time, want.colour, m_tdata[INDEX_W +: COLOUR_W]);
    end
    if (m_tlast !== want.last) begin
      errors++;
      $display("%0t: last_pixel expected %0b actual %0b", $time, want.last, m_tlast);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      grid_rows = GRID_RESET;
      grid_cols = GRID_RESET;
      pixel_due_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_pixel();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows = cfg_data;
          REG_GRID_COLS: grid_cols = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expand_rectangle(s_tuser, s_tdata);
    end
    pending_words <= pixel_due_q.size();
    fail_count <= errors;
    rects_seen <= rects;
    pixels_seen <= pixels;
  end

endmodule

// File: tb/serpentine_rectangle_rasterizer_core_test.sv
// stimulus and verdict for the serpentine rectangle rasterizer core
`timescale 1ns / 1ps

module serpentine_rectangle_rasterizer_core_test;
  import srr_pkg::*;

  localparam int SEGMENTS  = 10;
  localparam int SEG_ITEMS = 32;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  // grid settings per random segment, the last one is drawn at random
  localparam logic [COORD_W-1:0] SEG_ROWS [SEGMENTS] =
    '{4'd1, 4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7, 4'd0, 4'd5};
  localparam logic [COORD_W-1:0] SEG_COLS [SEGMENTS] =
    '{4'd1, 4'd8, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd6};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending_words;
  int rects_seen;
  int pixels_seen;

  int send_idle_pct = 22;
  int recv_idle_pct = 65;
  int side_rows = 8;
  int side_cols = 8;

  serpentine_rectangle_rasterizer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rectangle_pixel_checker pixel_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .rects_seen    (rects_seen),
    .pixels_seen   (pixels_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("serpentine_rectangle_rasterizer_core_test failed");
    $finish;
  end

  // side that the coordinates will be clamped to
  function automatic int usable_side(logic [COORD_W-1:0] v);
    if (v == 0) return 1;
    return (v > HW_LIMIT) ? HW_LIMIT : int'(v);
  endfunction

  // mostly inside the grid, sometimes anywhere in the 4-bit range
  function automatic logic [COORD_W-1:0] pick_coord(int side);
    if ($urandom_range(3) == 0) return COORD_W'($urandom_range(15));
    return COORD_W'($urandom_range(side, 1));
  endfunction

  // let every owed pixel word come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // one command word; tvalid stays up for a back-to-back successor
  task automatic send_rect(input logic fill, input logic [COORD_W-1:0] ra,
                           input logic [COORD_W-1:0] ca, input logic [COORD_W-1:0] rb,
                           input logic [COORD_W-1:0] cb, input logic [COLOUR_W-1:0] colour);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fill;
    s_tdata <= {colour, cb, rb, ca, ra};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // new grid size, only once the block has gone quiet
  task automatic set_grid(input logic [COORD_W-1:0] rows, input logic [COORD_W-1:0] cols,
                          input bit poke_spare);
    drain();
    cfg_put(REG_GRID_ROWS, rows);
    cfg_put(REG_GRID_COLS, cols);
    if (poke_spare) cfg_put(REG_SPARE, ~rows);
    cfg_valid <= 1'b0;
    side_rows = usable_side(rows);
    side_cols = usable_side(cols);
  endtask

  initial begin
    logic [COORD_W-1:0] rows_cfg;
    logic [COORD_W-1:0] cols_cfg;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed shapes on the reset grid
    send_rect(1'b1, 4'd1, 4'd1, 4'd8, 4'd8, 24'h000000);
    send_rect(1'b1, 4'd8, 4'd8, 4'd1, 4'd1, 24'hFFFFFF);
    send_rect(1'b0, 4'd1, 4'd1, 4'd8, 4'd8, 24'hAAAAAA);
    send_rect(1'b0, 4'd8, 4'd1, 4'd1, 4'd8, 24'h555555);
    send_rect(1'b1, 4'd1, 4'd1, 4'd1, 4'd1, 24'h0000FF);
    send_rect(1'b0, 4'd8, 4'd8, 4'd8, 4'd8, 24'h00FF00);
    // degenerate outlines: one row, one column
    send_rect(1'b0, 4'd3, 4'd2, 4'd3, 4'd7, 24'hFF0000);
    send_rect(1'b0, 4'd2, 4'd5, 4'd7, 4'd5, 24'h123456);
    // zero corners and corners past the grid
    send_rect(1'b1, 4'd0, 4'd0, 4'd2, 4'd3, 24'h800001);
    send_rect(1'b1, 4'd15, 4'd15, 4'd6, 4'd7, 24'h7FFFFE);
    send_rect(1'b0, 4'd0, 4'd15, 4'd15, 4'd0, 24'hC3C3C3);
    send_rect(1'b1, 4'd9, 4'd9, 4'd9, 4'd9, 24'h3C3C3C);
    // single rows of both strip directions and a single column
    send_rect(1'b1, 4'd4, 4'd1, 4'd4, 4'd8, 24'hABCDEF);
    send_rect(1'b1, 4'd5, 4'd8, 4'd5, 4'd1, 24'hFEDCBA);
    send_rect(1'b1, 4'd1, 4'd3, 4'd8, 4'd3, 24'h0F0F0F);
    send_rect(1'b0, 4'd2, 4'd3, 4'd6, 4'd5, 24'hF0F0F0);

    // random rectangles over a sweep of grid sizes and idling profiles
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg * 3 / SEGMENTS)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      rows_cfg = SEG_ROWS[seg];
      cols_cfg = SEG_COLS[seg];
      if (seg == SEGMENTS - 1) begin
        rows_cfg = COORD_W'($urandom_range(15));
        cols_cfg = COORD_W'($urandom_range(15));
      end
      set_grid(rows_cfg, cols_cfg, seg == 4);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // hold the sender until the block has emptied
        if (seg == 2 && k == SEG_ITEMS / 2) drain();
        send_rect(1'($urandom_range(1)), pick_coord(side_rows), pick_coord(side_cols),
                  pick_coord(side_rows), pick_coord(side_cols), COLOUR_W'($urandom));
      end
    end

    drain();
    repeat (70) @(posedge clk);

    $display("covered %0d rectangles, %0d pixel words, %0d grid settings",
             rects_seen, pixels_seen, SEGMENTS + 1);
    $display("idling sender-heavy, receiver-heavy and none; corners from 0 to 15");
    if (fail_count == 0) begin
      $display("serpentine_rectangle_rasterizer_core_test passed");
    end else begin
      $display("serpentine_rectangle_rasterizer_core_test failed");
    end
    $finish;
  end

endmodule
